// ===== hdl/multi_pattern_response_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// multi_pattern_response_matcher_defines
// assertion macros shared by the matcher rtl
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_RESPONSE_MATCHER_DEFINES_SVH
`define MULTI_PATTERN_RESPONSE_MATCHER_DEFINES_SVH

// same-cycle implication
`define MPRM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matcher assertion failed");

// next-cycle implication
`define MPRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matcher assertion failed");

`endif

// ===== hdl/mprm_pkg.sv =====
// ----------------------------------------------------------------------------
// mprm_pkg
// types and constants of the multi-pattern response matcher
// ----------------------------------------------------------------------------
package mprm_pkg;

   localparam int REG_SLOTS   = 3;
   localparam int POS_W       = 5;
   localparam int LEN_W       = 5;
   localparam int PAT_BYTES   = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int LENGTHS_W   = REG_SLOTS * LEN_W;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   // register map: pattern words first, then the packed lengths
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTHS = 3'd6;

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_ARM     = 2'd1,
      OP_DISARM  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_MATCH   = 2'd0,
      KIND_TEXT    = 2'd1,
      KIND_NEWLINE = 2'd2
   } kind_type;

   typedef logic [PAT_BYTES-1:0][7:0] pattern_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             hit;
   } slot_result_type;

endpackage

// ===== hdl/mprm_if.sv =====
// ----------------------------------------------------------------------------
// mprm_if
// valid/ready channels of the matcher: byte requests, results, register writes
// ----------------------------------------------------------------------------
interface mprm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] rx_byte;
   logic       chunk_end;

   modport source (output valid, opcode, rx_byte, chunk_end, input ready);
   modport sink   (input valid, opcode, rx_byte, chunk_end, output ready);
endinterface

interface mprm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [1:0] match_index;
   logic [7:0] captured_byte;
   logic       capture_last;

   modport source (output valid, kind, match_index, captured_byte, capture_last,
                   input ready);
   modport sink   (input valid, kind, match_index, captured_byte, capture_last,
                   output ready);
endinterface

interface mprm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mprm_pkg::CSR_INDEX_W-1:0]    index;
   logic [mprm_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/mprm_slot.sv =====
// ----------------------------------------------------------------------------
// mprm_slot
// one string comparator: next match position and completion for a byte
// ----------------------------------------------------------------------------
module mprm_slot #(
   parameter int MAX_PATTERN_LEN = 16
) (
   input  mprm_pkg::pattern_type          pattern,
   input  logic [mprm_pkg::LEN_W-1:0]     length,
   input  logic [mprm_pkg::POS_W-1:0]     pos,
   input  logic [7:0]                     rx_byte,
   output mprm_pkg::slot_result_type      result
);

   localparam logic [mprm_pkg::LEN_W-1:0] LEN_MAX = mprm_pkg::LEN_W'(MAX_PATTERN_LEN);

   logic [mprm_pkg::LEN_W-1:0] len_sat;
   logic [mprm_pkg::POS_W-1:0] pos_inc;
   logic                       byte_eq;
   logic                       advance;

   assign len_sat = (length > LEN_MAX) ? LEN_MAX : length;
   // string bytes past the stored sixteen read as zero
   assign byte_eq = pos[4] ? (rx_byte == 8'h00) : (rx_byte == pattern[pos[3:0]]);
   assign advance = (pos < len_sat) && byte_eq;
   assign pos_inc = pos + 1'b1;

   always_comb begin
      result.pos = '0;
      result.hit = 1'b0;
      if (len_sat != '0 && advance) begin
         if (pos_inc == len_sat) begin
            result.hit = 1'b1;
         end else begin
            result.pos = pos_inc;
         end
      end
   end

endmodule

// ===== hdl/multi_pattern_response_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_response_matcher
// watches a received byte stream for configured response strings
// ----------------------------------------------------------------------------
// Takes one request per clock and gives at most one result per request,
// in the cycle after the transfer. All string comparators look at the byte
// in the same cycle, so the rate is one byte per cycle; it is limited only
// by the single result register, and req ready stays high as long as that
// register is empty or is being taken in the same cycle. A request that
// makes no result is still accepted. Registers are written through the csr
// channel, which is always ready; write them only while no request is open.
// ----------------------------------------------------------------------------
`include "multi_pattern_response_matcher_defines.svh"

module multi_pattern_response_matcher #(
   parameter int NUM_PATTERNS    = 3,
   parameter int MAX_PATTERN_LEN = 16
) (
   input  logic       clock,
   input  logic       reset,
   mprm_req_if.sink   req_chan,
   mprm_rsp_if.source rsp_chan,
   mprm_csr_if.sink   csr_chan
);

   localparam int ACT_SLOTS = (NUM_PATTERNS < mprm_pkg::REG_SLOTS) ?
                              NUM_PATTERNS : mprm_pkg::REG_SLOTS;
   localparam int POS_W = mprm_pkg::POS_W;
   localparam int LEN_W = mprm_pkg::LEN_W;

   logic [mprm_pkg::CSR_DATA_W-1:0] pat_lo_ff [ACT_SLOTS];
   logic [mprm_pkg::CSR_DATA_W-1:0] pat_hi_ff [ACT_SLOTS];
   logic [mprm_pkg::LENGTHS_W-1:0]  lengths_ff;

   logic [POS_W-1:0] pos_ff [ACT_SLOTS];
   logic [POS_W-1:0] pos_in [ACT_SLOTS];
   logic             armed_ff, armed_in;
   logic             capturing_ff, capturing_in;

   logic               rsp_valid_ff, rsp_valid_in;
   mprm_pkg::kind_type kind_ff, kind_in;
   logic [1:0]         index_ff, index_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;

   mprm_pkg::slot_result_type slot_res [ACT_SLOTS];

   logic       req_fire;
   logic       csr_fire;
   logic       produce;
   logic       hit_any;
   logic [1:0] hit_idx;
   logic       rsp_stall;
   logic       arm_fire;
   logic       arm_settled;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;

   // ---------------------------------------------------------------- config
   genvar gs;
   generate
      for (gs = 0; gs < ACT_SLOTS; gs++) begin : g_slot
         always_ff @(posedge clock) begin
            if (reset) begin
               pat_lo_ff[gs] <= '0;
               pat_hi_ff[gs] <= '0;
            end else if (csr_fire && csr_chan.index < mprm_pkg::CSR_LENGTHS &&
                         csr_chan.index[2:1] == 2'(gs)) begin
               if (csr_chan.index[0]) begin
                  pat_hi_ff[gs] <= csr_chan.data;
               end else begin
                  pat_lo_ff[gs] <= csr_chan.data;
               end
            end
         end

         mprm_slot #(
            .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
         ) u_slot (
            .pattern (mprm_pkg::pattern_type'({pat_hi_ff[gs], pat_lo_ff[gs]})),
            .length  (lengths_ff[gs*LEN_W +: LEN_W]),
            .pos     (pos_ff[gs]),
            .rx_byte (req_chan.rx_byte),
            .result  (slot_res[gs])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         lengths_ff <= '0;
      end else if (csr_fire && csr_chan.index == mprm_pkg::CSR_LENGTHS) begin
         lengths_ff <= csr_chan.data[mprm_pkg::LENGTHS_W-1:0];
      end
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      // lowest index wins a tie
      for (int s = 0; s < ACT_SLOTS; s++) begin
         if (slot_res[s].hit && !hit_any) begin
            hit_any = 1'b1;
            hit_idx = 2'(s);
         end
      end
   end

   always_comb begin
      armed_in     = armed_ff;
      capturing_in = capturing_ff;
      pos_in       = pos_ff;
      produce      = 1'b0;
      kind_in      = mprm_pkg::KIND_MATCH;
      index_in     = '0;
      byte_in      = '0;
      last_in      = 1'b0;
      if (req_fire) begin
         unique case (req_chan.opcode)
            mprm_pkg::OP_ARM: begin
               for (int s = 0; s < ACT_SLOTS; s++) pos_in[s] = '0;
               armed_in     = 1'b1;
               capturing_in = 1'b0;
            end
            mprm_pkg::OP_DISARM: begin
               armed_in     = 1'b0;
               capturing_in = 1'b0;
            end
            mprm_pkg::OP_BYTE: begin
               if (capturing_ff) begin
                  produce = 1'b1;
                  last_in = 1'b1;
                  if (req_chan.rx_byte == mprm_pkg::NEWLINE_CHAR) begin
                     capturing_in = 1'b0;
                     kind_in      = mprm_pkg::KIND_NEWLINE;
                  end else begin
                     capturing_in = !req_chan.chunk_end;
                     kind_in      = mprm_pkg::KIND_TEXT;
                     byte_in      = req_chan.rx_byte;
                     last_in      = req_chan.chunk_end;
                  end
               end else if (armed_ff) begin
                  for (int s = 0; s < ACT_SLOTS; s++) pos_in[s] = slot_res[s].pos;
                  if (hit_any) begin
                     for (int s = 0; s < ACT_SLOTS; s++) pos_in[s] = '0;
                     armed_in     = 1'b0;
                     capturing_in = !req_chan.chunk_end;
                     produce      = 1'b1;
                     index_in     = hit_idx;
                     last_in      = req_chan.chunk_end;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = req_fire ? produce : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         capturing_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < ACT_SLOTS; s++) pos_ff[s] <= '0;
      end else begin
         armed_ff     <= armed_in;
         capturing_ff <= capturing_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && produce) begin
         kind_ff  <= kind_in;
         index_ff <= index_in;
         byte_ff  <= byte_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = kind_ff;
   assign rsp_chan.match_index   = index_ff;
   assign rsp_chan.captured_byte = byte_ff;
   assign rsp_chan.capture_last  = last_ff;

   // ---------------------------------------------------------------- checks
   assign rsp_stall   = rsp_valid_ff && !rsp_chan.ready;
   assign arm_fire    = req_fire && req_chan.opcode == mprm_pkg::OP_ARM;
   assign arm_settled = armed_ff && !capturing_ff && !rsp_valid_ff;

   `MPRM_ASSERT_NOW(a_capture_not_armed, clock, reset, capturing_ff, !armed_ff)
   `MPRM_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_stall, !req_chan.ready)
   `MPRM_ASSERT_NEXT(a_arm_starts_match, clock, reset, arm_fire, arm_settled)

endmodule
